>>> hw/rtl/atl_pkg.sv
// Shared types, constants and helper functions for the assembly token lexer.
// No dependencies; every other file in hw/rtl except atl_ifs uses this package by scoped names.
`default_nettype none

package atl_pkg;

  // Longest word kept in full; longer words flag truncation.
  localparam int MAX_WORD_BYTES = 8;
  // Bytes of a word shown in word_text and used for keyword matching.
  localparam int TEXT_BYTES     = 8;
  localparam int TEXT_IDX_W     = $clog2(TEXT_BYTES);
  localparam int COUNT_W        = 8;
  localparam int COUNT_MAX      = (1 << COUNT_W) - 1;

  // Result queue.
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam int NUM_INSTR      = 5;
  localparam int NUM_REGS       = 16;

  // Character codes.
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_A_LC   = 8'h61;
  localparam logic [7:0] CH_Z_LC   = 8'h7A;

  typedef enum logic [2:0] {
    KIND_EOF    = 3'd0,
    KIND_NUMBER = 3'd1,
    KIND_SYMBOL = 3'd2,
    KIND_IDENT  = 3'd3,
    KIND_INSTR  = 3'd4,
    KIND_REG    = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    SYM_SEP     = 3'd0,
    SYM_LABEL   = 3'd1,
    SYM_LBRACK  = 3'd2,
    SYM_RBRACK  = 3'd3,
    SYM_REMARK  = 3'd4,
    SYM_OTHER   = 3'd5
  } sym_t;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_NUMBER  = 4'b0010,
    MODE_WORD    = 4'b0100,
    MODE_COMMENT = 4'b1000
  } mode_t;

  typedef struct packed {
    kind_t                   kind;
    sym_t                    sym;
    logic [31:0]             num;
    logic [3:0]              kw;
    logic [8*TEXT_BYTES-1:0] text;
    logic [COUNT_W-1:0]      len;
    logic                    trunc;
    logic                    last;
  } token_t;

  // Up to two tokens produced by one accepted transaction, in order.
  typedef struct packed {
    logic [1:0] n;
    token_t     first;
    token_t     second;
  } push_t;

  // Keyword text, first character in the low byte, zero padded.
  localparam logic [63:0] INSTR_TEXT [NUM_INSTR] = '{
    64'h0000_0000_0076_6F6D,   // mov
    64'h0000_0000_0064_6461,   // add
    64'h0000_0000_0070_6D6A,   // jmp
    64'h006C_6C61_6373_7973,   // syscall
    64'h0000_0000_0074_6572    // ret
  };
  localparam logic [COUNT_W-1:0] INSTR_LEN [NUM_INSTR] = '{
    8'd3, 8'd3, 8'd3, 8'd7, 8'd3
  };

  localparam logic [63:0] REG_TEXT [NUM_REGS] = '{
    64'h0000_0000_0078_6172,   // rax
    64'h0000_0000_0078_6272,   // rbx
    64'h0000_0000_0078_6372,   // rcx
    64'h0000_0000_0078_6472,   // rdx
    64'h0000_0000_0069_7372,   // rsi
    64'h0000_0000_0069_6472,   // rdi
    64'h0000_0000_0078_6165,   // eax
    64'h0000_0000_0078_6265,   // ebx
    64'h0000_0000_0078_6365,   // ecx
    64'h0000_0000_0078_6465,   // edx
    64'h0000_0000_0069_7365,   // esi
    64'h0000_0000_0069_6465,   // edi
    64'h0000_0000_0000_6C61,   // al
    64'h0000_0000_0000_6C62,   // bl
    64'h0000_0000_0000_6C63,   // cl
    64'h0000_0000_0000_6C64    // dl
  };
  localparam logic [COUNT_W-1:0] REG_LEN [NUM_REGS] = '{
    8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
    8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
    8'd2, 8'd2, 8'd2, 8'd2
  };

  function automatic logic is_numeral(input logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

  function automatic logic is_word_byte(input logic [7:0] c);
    return (c inside {[CH_0:CH_9], [CH_A_LC:CH_Z_LC]}) || (c == CH_DOT) || (c == CH_UNDER);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/atl_ifs.sv
// Valid/ready channel interfaces for the lexer: source text in, tokens out.
// Depends on nothing; widths follow the token field definitions.
`default_nettype none

interface atl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source (output valid, char_byte, end_of_text, input ready);
  modport sink   (input valid, char_byte, end_of_text, output ready);
endinterface

interface atl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [2:0]  symbol_code;
  logic [31:0] number_value;
  logic [3:0]  keyword_index;
  logic [63:0] word_text;
  logic [7:0]  word_length;
  logic        word_truncated;
  logic        last_of_run;

  modport source (output valid, token_kind, symbol_code, number_value, keyword_index,
                  word_text, word_length, word_truncated, last_of_run, input ready);
  modport sink   (input valid, token_kind, symbol_code, number_value, keyword_index,
                  word_text, word_length, word_truncated, last_of_run, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/atl_classify.sv
// Keyword classifier: matches the stored word against the mnemonic and register tables.
// Depends on atl_pkg.
`default_nettype none

module atl_classify (
  input  wire logic [8*atl_pkg::TEXT_BYTES-1:0] text,
  input  wire logic [atl_pkg::COUNT_W-1:0]      count,
  output atl_pkg::kind_t                        kind,
  output logic [3:0]                            kw
);

  always_comb begin
    kind = atl_pkg::KIND_IDENT;
    kw   = '0;
    for (int i = 0; i < atl_pkg::NUM_INSTR; i++) begin
      if (count == atl_pkg::INSTR_LEN[i] && text == atl_pkg::INSTR_TEXT[i]) begin
        kind = atl_pkg::KIND_INSTR;
        kw   = 4'(i);
      end
    end
    for (int i = 0; i < atl_pkg::NUM_REGS; i++) begin
      if (count == atl_pkg::REG_LEN[i] && text == atl_pkg::REG_TEXT[i]) begin
        kind = atl_pkg::KIND_REG;
        kw   = 4'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/atl_core.sv
// Scanner core: scan state registers and the per-byte token logic.
// Depends on atl_pkg and atl_classify.
`default_nettype none

module atl_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic [7:0] char_byte,
  input  wire logic       end_of_text,
  output atl_pkg::push_t  push
);

  localparam int TW = 8 * atl_pkg::TEXT_BYTES;

  atl_pkg::mode_t               mode_r,  mode_nxt;
  logic [31:0]                  acc_r,   acc_nxt;
  logic [TW-1:0]                text_r,  text_nxt;
  logic [atl_pkg::COUNT_W-1:0]  count_r, count_nxt;

  atl_pkg::kind_t word_kind;
  logic [3:0]     word_kw;

  atl_pkg::token_t flush_tok, sym_tok, eof_tok, tok_a, tok_b;
  logic            has_flush;
  logic            gen_sym;
  logic [1:0]      n;
  logic [7:0]      digit;

  atl_classify u_classify (
    .text  (text_r),
    .count (count_r),
    .kind  (word_kind),
    .kw    (word_kw)
  );

  assign digit = char_byte - atl_pkg::CH_0;

  // Token for whatever number or word is pending in the state.
  always_comb begin
    flush_tok = '0;
    has_flush = 1'b0;
    case (mode_r)
      atl_pkg::MODE_NUMBER: begin
        has_flush     = 1'b1;
        flush_tok.kind = atl_pkg::KIND_NUMBER;
        flush_tok.num  = acc_r;
      end
      atl_pkg::MODE_WORD: begin
        has_flush       = 1'b1;
        flush_tok.kind  = word_kind;
        flush_tok.kw    = word_kw;
        flush_tok.text  = text_r;
        flush_tok.len   = count_r;
        flush_tok.trunc = (count_r > atl_pkg::COUNT_W'(atl_pkg::MAX_WORD_BYTES));
      end
      default: ;
    endcase
  end

  always_comb begin
    eof_tok = '0;
    eof_tok.kind = atl_pkg::KIND_EOF;
  end

  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    text_nxt  = text_r;
    count_nxt = count_r;
    sym_tok   = '0;
    sym_tok.kind = atl_pkg::KIND_SYMBOL;
    gen_sym   = 1'b0;
    tok_a     = '0;
    tok_b     = '0;
    n         = 2'd0;

    if (end_of_text) begin
      // flush, emit EOF, return to reset state
      mode_nxt  = atl_pkg::MODE_IDLE;
      acc_nxt   = '0;
      text_nxt  = '0;
      count_nxt = '0;
      tok_a     = has_flush ? flush_tok : eof_tok;
      tok_b     = eof_tok;
      n         = has_flush ? 2'd2 : 2'd1;
    end else if (mode_r == atl_pkg::MODE_COMMENT) begin
      if (char_byte == atl_pkg::CH_NL) begin
        mode_nxt = atl_pkg::MODE_IDLE;
      end
    end else if (mode_r == atl_pkg::MODE_NUMBER && atl_pkg::is_numeral(char_byte)) begin
      acc_nxt = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0} + {24'd0, digit};
    end else if (mode_r == atl_pkg::MODE_WORD && atl_pkg::is_word_byte(char_byte)) begin
      if (count_r < atl_pkg::COUNT_W'(atl_pkg::TEXT_BYTES)) begin
        text_nxt[8*count_r[atl_pkg::TEXT_IDX_W-1:0] +: 8] = char_byte;
      end
      if (count_r != atl_pkg::COUNT_W'(atl_pkg::COUNT_MAX)) begin
        count_nxt = count_r + 1'b1;
      end
    end else begin
      // pending token (if any) ends here; byte then starts what follows
      mode_nxt = atl_pkg::MODE_IDLE;
      if (char_byte == atl_pkg::CH_SPACE || char_byte == atl_pkg::CH_NL) begin
        mode_nxt = atl_pkg::MODE_IDLE;
      end else if (atl_pkg::is_numeral(char_byte)) begin
        mode_nxt = atl_pkg::MODE_NUMBER;
        acc_nxt  = {24'd0, digit};
      end else if (atl_pkg::is_word_byte(char_byte)) begin
        mode_nxt  = atl_pkg::MODE_WORD;
        text_nxt  = {{(TW-8){1'b0}}, char_byte};
        count_nxt = atl_pkg::COUNT_W'(1);
      end else begin
        gen_sym = 1'b1;
        case (char_byte)
          atl_pkg::CH_COMMA:  sym_tok.sym = atl_pkg::SYM_SEP;
          atl_pkg::CH_COLON:  sym_tok.sym = atl_pkg::SYM_LABEL;
          atl_pkg::CH_LBRACK: sym_tok.sym = atl_pkg::SYM_LBRACK;
          atl_pkg::CH_RBRACK: sym_tok.sym = atl_pkg::SYM_RBRACK;
          atl_pkg::CH_SEMI: begin
            sym_tok.sym = atl_pkg::SYM_REMARK;
            mode_nxt    = atl_pkg::MODE_COMMENT;
          end
          default:            sym_tok.sym = atl_pkg::SYM_OTHER;
        endcase
      end
      tok_a = has_flush ? flush_tok : sym_tok;
      tok_b = sym_tok;
      n     = {1'b0, has_flush} + {1'b0, gen_sym};
    end

    tok_a.last = (n == 2'd1);
    tok_b.last = 1'b1;
  end

  assign push.n      = n;
  assign push.first  = tok_a;
  assign push.second = tok_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= atl_pkg::MODE_IDLE;
      acc_r   <= '0;
      text_r  <= '0;
      count_r <= '0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      text_r  <= text_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/atl_queue.sv
// Result queue: holds finished tokens until the sink takes them; takes up to two per push.
// Depends on atl_pkg.
`default_nettype none

module atl_queue (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push_en,
  input  atl_pkg::push_t  push,
  output logic            has_room,
  output logic            out_valid,
  input  wire logic       out_ready,
  output atl_pkg::token_t out_tok
);

  atl_pkg::token_t               q_r [atl_pkg::QUEUE_DEPTH];
  logic [atl_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [atl_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [atl_pkg::QCNT_W-1:0]    cnt_r,    cnt_nxt;
  logic [1:0]                    push_n;
  logic                          pop;
  logic [atl_pkg::QPTR_W-1:0]    wr_ptr_p1;

  assign push_n    = push_en ? push.n : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_tok   = q_r[rd_ptr_r];
  // room for a transaction that makes two tokens, independent of out_ready
  assign has_room  = (cnt_r <= atl_pkg::QCNT_W'(atl_pkg::QUEUE_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  assign wr_ptr_nxt = wr_ptr_r + atl_pkg::QPTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + atl_pkg::QPTR_W'(pop);
  assign cnt_nxt    = cnt_r + atl_pkg::QCNT_W'(push_n) - atl_pkg::QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= push.first;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_p1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/assembly_token_lexer_unit.sv
// Assembly token lexer top level: scanner core feeding a four-entry result queue.
// Depends on atl_pkg, atl_ifs, atl_core and atl_queue.
// Output: each token is written into the result queue and reaches out_chan behind any tokens queued before it.
// Throughput: one byte per cycle while in_chan.ready is high; a byte that ends a token and makes another
//   pushes two tokens into the queue, and in_chan.ready drops while the queue holds three or more.
// Reset: synchronous, active low; clears the scan state and empties the queue.
`default_nettype none

module assembly_token_lexer_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  atl_in_if.sink      in_chan,
  atl_out_if.source   out_chan
);

  atl_pkg::push_t  push;
  atl_pkg::token_t head;
  logic            has_room;
  logic            in_fire;

  assign in_chan.ready = has_room;
  assign in_fire       = in_chan.valid && has_room;

  atl_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .char_byte   (in_chan.char_byte),
    .end_of_text (in_chan.end_of_text),
    .push        (push)
  );

  atl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (in_fire),
    .push      (push),
    .has_room  (has_room),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_tok   (head)
  );

  assign out_chan.token_kind     = head.kind;
  assign out_chan.symbol_code    = head.sym;
  assign out_chan.number_value   = head.num;
  assign out_chan.keyword_index  = head.kw;
  assign out_chan.word_text      = head.text;
  assign out_chan.word_length    = head.len;
  assign out_chan.word_truncated = head.trunc;
  assign out_chan.last_of_run    = head.last;

endmodule

`default_nettype wire

>>> hw/rtl/atl_checker.sv
// Port-level checks for the assembly token lexer, bound to the top level.
// Depends on atl_pkg and assembly_token_lexer_unit.
`default_nettype none

module atl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  token_kind,
  input wire logic [63:0] word_text,
  input wire logic [7:0]  word_length,
  input wire logic        word_truncated,
  input wire logic        last_of_run
);

  logic is_word;
  assign is_word = (token_kind == atl_pkg::KIND_IDENT) || (token_kind == atl_pkg::KIND_INSTR)
                || (token_kind == atl_pkg::KIND_REG);

  // queue is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("token presented right after reset");

  // a stalled token holds
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(word_text))
    else $error("stalled token changed");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_kind == atl_pkg::KIND_EOF |-> last_of_run)
    else $error("EOF token not marked last");

  a_nonword_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_word |-> word_length == 8'd0 && word_text == 64'd0 && !word_truncated)
    else $error("non-word token carries word fields");

  a_trunc_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_word |->
      word_length != 8'd0 &&
      word_truncated == (word_length > 8'(atl_pkg::MAX_WORD_BYTES)))
    else $error("word truncation flag disagrees with length");

endmodule

bind assembly_token_lexer_unit atl_checker u_atl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .token_kind     (out_chan.token_kind),
  .word_text      (out_chan.word_text),
  .word_length    (out_chan.word_length),
  .word_truncated (out_chan.word_truncated),
  .last_of_run    (out_chan.last_of_run)
);

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for assembly_token_lexer_unit: sends source bytes and
// end-of-text marks, predicts the token stream, and compares every token field.
// Depends on atl_pkg, atl_ifs and the lexer RTL.
`timescale 1ns / 100ps

module testbench;
  import atl_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  atl_in_if  in_chan ();
  atl_out_if out_chan ();

  assembly_token_lexer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  string instr_names [NUM_INSTR] = '{"mov", "add", "jmp", "syscall", "ret"};
  string reg_names [NUM_REGS] = '{"rax", "rbx", "rcx", "rdx", "rsi", "rdi",
                                  "eax", "ebx", "ecx", "edx", "esi", "edi",
                                  "al", "bl", "cl", "dl"};

  // Scanner state mirrored by the token predictor.
  mode_t       scan_mode;
  logic [31:0] num_acc;
  logic [7:0]  word_buf [MAX_WORD_BYTES];
  logic [7:0]  word_len;

  token_t tokens_due [$];
  token_t step_tokens [$];

  int mismatch_count = 0;
  int tokens_seen = 0;
  int bytes_sent = 0;
  int texts_ended = 0;
  int long_words_left = 3;
  int holds_done = 0;
  int kind_count [6] = '{default: 0};
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  bit holding = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic bit is_decimal(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return is_decimal(c) || (c >= CH_A_LC && c <= CH_Z_LC) || c == CH_DOT || c == CH_UNDER;
  endfunction

  function automatic void clear_scan();
    scan_mode = MODE_IDLE;
    num_acc = '0;
    foreach (word_buf[i]) word_buf[i] = '0;
    word_len = '0;
  endfunction

  function automatic bit word_is(string name);
    if (word_len != name.len()) return 1'b0;
    for (int i = 0; i < name.len(); i++) begin
      if (word_buf[i] != name[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void add_word_char(logic [7:0] c);
    if (word_len < MAX_WORD_BYTES) word_buf[word_len] = c;
    if (word_len != 8'hFF) word_len++;
  endfunction

  // Emit the number or word in progress, if any, and drop back to idle.
  function automatic void flush_token();
    token_t t;
    t = '0;
    if (scan_mode == MODE_NUMBER) begin
      t.kind = KIND_NUMBER;
      t.num = num_acc;
      step_tokens.push_back(t);
    end else if (scan_mode == MODE_WORD) begin
      t.kind = KIND_IDENT;
      for (int i = 0; i < MAX_WORD_BYTES && i < word_len; i++) t.text[8*i +: 8] = word_buf[i];
      t.len = word_len;
      t.trunc = (word_len > MAX_WORD_BYTES);
      foreach (instr_names[i]) begin
        if (word_is(instr_names[i])) begin
          t.kind = KIND_INSTR;
          t.kw = 4'(i);
        end
      end
      foreach (reg_names[i]) begin
        if (word_is(reg_names[i])) begin
          t.kind = KIND_REG;
          t.kw = 4'(i);
        end
      end
      step_tokens.push_back(t);
    end
    scan_mode = MODE_IDLE;
  endfunction

  function automatic void begin_token(logic [7:0] c);
    token_t t;
    t = '0;
    if (c == CH_SPACE || c == CH_NL) return;
    if (is_decimal(c)) begin
      scan_mode = MODE_NUMBER;
      num_acc = 32'(c - CH_0);
    end else if (is_word_char(c)) begin
      scan_mode = MODE_WORD;
      foreach (word_buf[i]) word_buf[i] = '0;
      word_len = '0;
      add_word_char(c);
    end else begin
      t.kind = KIND_SYMBOL;
      case (c)
        CH_COMMA:  t.sym = SYM_SEP;
        CH_COLON:  t.sym = SYM_LABEL;
        CH_LBRACK: t.sym = SYM_LBRACK;
        CH_RBRACK: t.sym = SYM_RBRACK;
        CH_SEMI: begin
          t.sym = SYM_REMARK;
          scan_mode = MODE_COMMENT;
        end
        default:   t.sym = SYM_OTHER;
      endcase
      step_tokens.push_back(t);
    end
  endfunction

  // Advance the scanner by one accepted transaction and queue the tokens it makes.
  function automatic void lex_step(logic [7:0] c, logic eot);
    token_t t;
    bit take_new;
    step_tokens.delete();
    take_new = 1'b1;
    if (eot) begin
      flush_token();
      t = '0;
      t.kind = KIND_EOF;
      step_tokens.push_back(t);
      clear_scan();
    end else begin
      case (scan_mode)
        MODE_COMMENT: begin
          if (c == CH_NL) scan_mode = MODE_IDLE;
          take_new = 1'b0;
        end
        MODE_NUMBER: begin
          if (is_decimal(c)) begin
            num_acc = num_acc * 32'd10 + 32'(c - CH_0);
            take_new = 1'b0;
          end else begin
            flush_token();
          end
        end
        MODE_WORD: begin
          if (is_word_char(c)) begin
            add_word_char(c);
            take_new = 1'b0;
          end else begin
            flush_token();
          end
        end
        default: ;
      endcase
      if (take_new) begin_token(c);
    end
    if (step_tokens.size() > 0) begin
      t = step_tokens.pop_back();
      t.last = 1'b1;
      step_tokens.push_back(t);
    end
    foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic int idle_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one transaction; valid stays high straight into the next one when no gap follows.
  task automatic send_item(logic [7:0] c, logic eot);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.char_byte <= c;
    in_chan.end_of_text <= eot;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    lex_step(c, eot);
    if (eot) texts_ended++;
    else bytes_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] word_char(int r);
    if (r < 26) return CH_A_LC + 8'(r);
    if (r == 26) return CH_DOT;
    if (r == 27) return CH_UNDER;
    return CH_0 + 8'(r - 28);
  endfunction

  task automatic send_random_word();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
    if (long_words_left > 0 && $urandom_range(149) == 0) begin
      long_words_left--;
      len = $urandom_range(250, 300);
    end
    for (int i = 0; i < len; i++) send_item(word_char($urandom_range(i == 0 ? 27 : 37)), 1'b0);
  endtask

  task automatic send_random_number();
    int len;
    len = ($urandom_range(4) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
    repeat (len) send_item(CH_0 + 8'($urandom_range(9)), 1'b0);
  endtask

  task automatic send_comment();
    send_item(CH_SEMI, 1'b0);
    repeat ($urandom_range(8)) send_item(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic send_operand();
    case ($urandom_range(5))
      0, 1: send_text(reg_names[$urandom_range(NUM_REGS - 1)]);
      2:    send_random_number();
      3: begin
        send_item(CH_LBRACK, 1'b0);
        send_text(reg_names[$urandom_range(NUM_REGS - 1)]);
        send_item(CH_RBRACK, 1'b0);
      end
      4:    send_random_word();
      default: begin
        // near miss: a register name with one more character
        send_text(reg_names[$urandom_range(NUM_REGS - 1)]);
        send_item(word_char($urandom_range(37)), 1'b0);
      end
    endcase
  endtask

  task automatic send_random_line();
    int r;
    int n;
    r = $urandom_range(9);
    if (r < 2) begin
      send_random_word();
      send_item(CH_COLON, 1'b0);
    end else if (r < 8) begin
      send_text(instr_names[$urandom_range(NUM_INSTR - 1)]);
      n = $urandom_range(2);
      for (int i = 0; i < n; i++) begin
        if (i > 0) send_item(CH_COMMA, 1'b0);
        if (i == 0 || $urandom_range(1)) send_item(CH_SPACE, 1'b0);
        send_operand();
      end
    end else begin
      send_random_word();
      send_item(CH_SPACE, 1'b0);
      send_random_number();
    end
    if ($urandom_range(3) == 0) begin
      send_comment();
      send_item(CH_NL, 1'b0);
    end else begin
      send_item(($urandom_range(3) == 0) ? CH_SPACE : CH_NL, 1'b0);
    end
  endtask

  // End the text in the middle of a number, a word or a comment.
  task automatic send_broken_tail();
    case ($urandom_range(2))
      0:       send_random_number();
      1:       send_random_word();
      default: send_comment();
    endcase
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_keyword_then_comma();
    send_text("mov r1,");
  endtask

  task automatic test_number_letter_split();
    send_text("9a:[");
  endtask

  task automatic test_extreme_bytes();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
  endtask

  task automatic test_long_word();
    send_text("syscalls.");
  endtask

  task automatic test_comment_at_end();
    send_item(CH_SEMI, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
  endtask

  // Hold the token output off for a long stretch while bytes keep coming.
  task automatic test_output_backpressure();
    idle_on = 1'b0;
    hold_request = 1'b1;
    // drop valid while waiting so the last transaction is not taken again
    in_chan.valid <= 1'b0;
    while (!holding) @(posedge clk);
    repeat (6) send_random_line();
    idle_on = 1'b1;
  endtask

  task automatic test_random_programs();
    int r;
    int stop_at;
    stop_at = bytes_sent + texts_ended + RANDOM_ITEMS;
    while (bytes_sent + texts_ended < stop_at) begin
      idle_on = ((bytes_sent / 300) % 4) != 3;
      r = $urandom_range(99);
      if (r < 75) send_random_line();
      else if (r < 85) send_item(8'($urandom_range(255)), 1'b0);
      else if (r < 93) send_broken_tail();
      else send_item(8'($urandom_range(255)), 1'b1);
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] seen);
    if (seen !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, field, want, seen);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : token_checker
    token_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      tokens_seen++;
      if (out_chan.token_kind < 6) kind_count[out_chan.token_kind]++;
      if (tokens_due.size() == 0) begin
        $display("%0t: token_kind expected none got %0h", $time, out_chan.token_kind);
        mismatch_count++;
      end else begin
        want = tokens_due.pop_front();
        check_field("token_kind", want.kind, out_chan.token_kind);
        check_field("symbol_code", want.sym, out_chan.symbol_code);
        check_field("number_value", want.num, out_chan.number_value);
        check_field("keyword_index", want.kw, out_chan.keyword_index);
        check_field("word_text", want.text, out_chan.word_text);
        check_field("word_length", want.len, out_chan.word_length);
        check_field("word_truncated", want.trunc, out_chan.word_truncated);
        check_field("last_of_run", want.last, out_chan.last_of_run);
      end
    end
  end

  // Token receiver: runs of ready, random stalls, and one long hold on request.
  initial begin : token_receiver
    int gap;
    out_chan.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_chan.ready <= 1'b0;
        hold_request = 1'b0;
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
        holds_done++;
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : sequencer
    in_chan.valid = 1'b0;
    in_chan.char_byte = '0;
    in_chan.end_of_text = 1'b0;
    clear_scan();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_keyword_then_comma();
    test_number_letter_split();
    test_extreme_bytes();
    test_long_word();
    test_comment_at_end();
    test_output_backpressure();
    test_random_programs();

    in_chan.valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d source bytes, %0d end-of-text marks, %0d long output holds",
             bytes_sent, texts_ended, holds_done);
    $display("checked %0d tokens: eof %0d number %0d symbol %0d ident %0d instr %0d reg %0d",
             tokens_seen, kind_count[0], kind_count[1], kind_count[2], kind_count[3],
             kind_count[4], kind_count[5]);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("%0t: timeout with %0d tokens still due", $time, tokens_due.size());
    $display("status: fail");
    $finish;
  end

endmodule
